>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define WWG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// property checked at every edge, reset included
`define WWG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: assertion failed");

`endif

>>> rtl/wwg_pkg.sv
// shared types, register codes and the cell rule of the wireworld stepper
// no dependencies
package wwg_pkg;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_HEAD  = 2'd1,
        ST_TAIL  = 2'd2,
        ST_COND  = 2'd3
    } t_cell;

    // what the front tells the back about one item
    typedef struct packed {
        logic emit;      // a result leaves with this item
        logic last;      // result is the final cell of the grid
        logic top_ok;    // row above the center lies on the grid
        logic bot_ok;    // row below the center lies on the grid
        logic left_ok;   // column left of the center lies on the grid
        logic right_ok;  // column right of the center is the incoming one
    } t_flags;

    function automatic logic [1:0] next_cell(input logic [1:0] s, input logic [3:0] heads);
        logic [1:0] r;
        case (t_cell'(s))
            ST_HEAD: r = ST_TAIL;
            ST_TAIL: r = ST_COND;
            ST_COND: r = (heads == 4'd1 || heads == 4'd2) ? ST_HEAD : ST_COND;
            default: r = ST_EMPTY;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/wwg_if.sv
// valid/ready channels of the wireworld stepper: cells in, results out, register writes
// depends on wwg_pkg
interface wwg_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] cell_state;
    modport source(output valid, kind, cell_state, input ready);
    modport sink(input valid, kind, cell_state, output ready);
endinterface

interface wwg_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] next_state;
    logic       last_of_frame;
    modport source(output valid, next_state, last_of_frame, input ready);
    modport sink(input valid, next_state, last_of_frame, output ready);
endinterface

interface wwg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wwg_pkg::CFG_IDX_W-1:0] index;
    logic [wwg_pkg::CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/wwg_front.sv
// front end: takes cells and register writes, tracks the raster position
// and classifies each item for the back end; depends on wwg_pkg, wwg_if
module wwg_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int AW         = $clog2(MAX_WIDTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wwg_item_if.sink        i_item,
    wwg_cfg_if.sink         i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output logic [AW-1:0]   o_addr,
    output logic [1:0]      o_cell,
    output wwg_pkg::t_flags o_flags,
    output logic            o_restart
);
    import wwg_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int RST_W = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
    localparam int RST_H = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

    logic [CW-1:0] r_width, n_width;
    logic [HW-1:0] r_height, n_height;
    logic [AW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic                    in_acc, cfg_acc, data_phase, emit_a, emit_b, row_end;
    logic [WIDTH_REG_W-1:0]  wv;
    logic [HEIGHT_REG_W-1:0] hv;
    t_flags                  fl;

    assign i_item.ready = !i_q_full;
    assign i_cfg.ready  = 1'b1;
    assign in_acc       = i_item.valid && i_item.ready;
    assign cfg_acc      = i_cfg.valid && i_cfg.ready;
    assign o_restart    = cfg_acc;

    assign wv = i_cfg.data[WIDTH_REG_W-1:0];
    assign hv = i_cfg.data[HEIGHT_REG_W-1:0];

    assign data_phase = 32'(r_row) < 32'(r_height);
    assign emit_a     = (r_col == '0) && (32'(r_row) >= 32'd2);
    assign emit_b     = (r_col != '0) && (32'(r_row) >= 32'd1);
    assign row_end    = (32'(r_col) + 32'd1) >= 32'(r_width);

    always_comb begin
        fl.emit     = emit_a || emit_b;
        fl.last     = emit_a && (32'(r_row) == 32'(r_height) + 32'd1);
        fl.right_ok = emit_b;
        if (emit_a) begin
            // center is the last cell of the row two back
            fl.top_ok  = 32'(r_row) >= 32'd3;
            fl.bot_ok  = 32'(r_row) <= 32'(r_height);
            fl.left_ok = 32'(r_width) >= 32'd2;
        end else begin
            fl.top_ok  = 32'(r_row) >= 32'd2;
            fl.bot_ok  = data_phase;
            fl.left_ok = 32'(r_col) >= 32'd2;
        end
    end

    // drain ticks inside the grid are dropped
    assign o_push  = in_acc && !(i_item.kind && data_phase);
    assign o_addr  = r_col;
    assign o_cell  = data_phase ? i_item.cell_state : ST_EMPTY;
    assign o_flags = fl;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        if (cfg_acc) begin
            case (t_reg_idx'(i_cfg.index))
                REG_GRID_WIDTH: begin
                    if (wv == '0)
                        n_width = CW'(1);
                    else if (32'(wv) > MAX_WIDTH)
                        n_width = CW'(MAX_WIDTH);
                    else
                        n_width = CW'(wv);
                end
                REG_GRID_HEIGHT: begin
                    if (hv == '0)
                        n_height = HW'(1);
                    else if (32'(hv) > MAX_HEIGHT)
                        n_height = HW'(MAX_HEIGHT);
                    else
                        n_height = HW'(hv);
                end
                default: ;
            endcase
            n_col = '0;
            n_row = '0;
        end else if (o_push) begin
            if (fl.last) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CW'(RST_W);
            r_height <= HW'(RST_H);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

>>> rtl/wwg_queue.sv
// short queue between front and back end
// no dependencies
module wwg_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output logic [DW-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_full  = 32'(r_cnt) == DEPTH;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + PW'(1);
            if (i_pop)
                r_rd <= (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + PW'(1);
            if (i_push && !i_pop)
                r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push)
                r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

>>> rtl/wwg_back.sv
// back end: line buffers, 3x3 window (two stored columns plus the incoming one),
// neighbor count and output register; depends on wwg_pkg, wwg_if
module wwg_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  logic [AW-1:0]   i_addr,
    input  logic [1:0]      i_cell,
    input  wwg_pkg::t_flags i_flags,
    input  logic            i_restart,
    output logic            o_pop,
    wwg_result_if.source    o_result
);
    import wwg_pkg::*;

    logic [1:0] r_above [MAX_WIDTH];
    logic [1:0] r_cur   [MAX_WIDTH];

    logic          r_s1_valid;
    logic [AW-1:0] r_s1_addr;
    logic [1:0]    r_s1_cell;
    t_flags        r_s1_flags;
    logic [1:0]    r_rd_top, r_rd_mid;

    // r_win1 is the left column, r_win2 the center column; index 0 is the top row
    logic [1:0] r_win1 [3];
    logic [1:0] r_win2 [3];

    logic       r_out_valid;
    logic [1:0] r_out_state;
    logic       r_out_last;

    logic       adv, fwd;
    logic [7:0] hit;
    logic [3:0] heads;
    logic [1:0] ns;

    assign adv   = r_s1_valid && (!r_out_valid || o_result.ready);
    assign o_pop = i_q_valid && (!r_s1_valid || adv);
    assign fwd   = adv && (r_s1_addr == i_addr);

    // line buffers: written as the item leaves stage one, read as the next one enters
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_above[r_s1_addr] <= r_rd_mid;
            r_cur[r_s1_addr]   <= r_s1_cell;
        end
        if (o_pop) begin
            r_rd_top   <= fwd ? r_rd_mid : r_above[i_addr];
            r_rd_mid   <= fwd ? r_s1_cell : r_cur[i_addr];
            r_s1_addr  <= i_addr;
            r_s1_cell  <= i_cell;
            r_s1_flags <= i_flags;
        end
    end

    always_comb begin
        hit[0] = r_s1_flags.left_ok && r_s1_flags.top_ok && r_win1[0] == ST_HEAD;
        hit[1] = r_s1_flags.left_ok && r_win1[1] == ST_HEAD;
        hit[2] = r_s1_flags.left_ok && r_s1_flags.bot_ok && r_win1[2] == ST_HEAD;
        hit[3] = r_s1_flags.top_ok && r_win2[0] == ST_HEAD;
        hit[4] = r_s1_flags.bot_ok && r_win2[2] == ST_HEAD;
        hit[5] = r_s1_flags.right_ok && r_s1_flags.top_ok && r_rd_top == ST_HEAD;
        hit[6] = r_s1_flags.right_ok && r_rd_mid == ST_HEAD;
        hit[7] = r_s1_flags.right_ok && r_s1_flags.bot_ok && r_s1_cell == ST_HEAD;
        heads  = '0;
        for (int k = 0; k < 8; k++)
            heads = heads + 4'(hit[k]);
        ns = next_cell(r_win2[1], heads);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            for (int k = 0; k < 3; k++) begin
                r_win1[k] <= ST_EMPTY;
                r_win2[k] <= ST_EMPTY;
            end
        end else if (adv) begin
            if (r_s1_flags.last) begin
                for (int k = 0; k < 3; k++) begin
                    r_win1[k] <= ST_EMPTY;
                    r_win2[k] <= ST_EMPTY;
                end
            end else begin
                for (int k = 0; k < 3; k++)
                    r_win1[k] <= r_win2[k];
                r_win2[0] <= r_rd_top;
                r_win2[1] <= r_rd_mid;
                r_win2[2] <= r_s1_cell;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop)
                r_s1_valid <= 1'b1;
            else if (adv)
                r_s1_valid <= 1'b0;
            if (adv && r_s1_flags.emit)
                r_out_valid <= 1'b1;
            else if (o_result.ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_flags.emit) begin
            r_out_state <= ns;
            r_out_last  <= r_s1_flags.last;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.next_state    = r_out_state;
    assign o_result.last_of_frame = r_out_last;

endmodule

>>> rtl/wireworld_generation_step.sv
// Wireworld generation step on a raster stream: one cell per cycle unless results stall.
// An accepted item passes the queue, the line buffer read and the output register; its
// result belongs to the cell one row plus one back.
// Each line buffer does one read and one write per item: 1 item/cycle while results flow.
// Synchronous reset clears positions, window and handshakes; line buffers are not cleared.
module wireworld_generation_step #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wwg_item_if.sink     i_item,
    wwg_cfg_if.sink      i_cfg,
    wwg_result_if.source o_result
);
    import wwg_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = AW + 2 + $bits(t_flags);

    logic          push, pop, q_valid, q_full, restart;
    logic [AW-1:0] f_addr, b_addr;
    logic [1:0]    f_cell, b_cell;
    t_flags        f_flags, b_flags;
    logic [QW-1:0] q_out;

    wwg_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .AW        (AW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_addr   (f_addr),
        .o_cell   (f_cell),
        .o_flags  (f_flags),
        .o_restart(restart)
    );

    wwg_queue #(
        .DW   (QW),
        .DEPTH(4)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_addr, f_cell, f_flags}),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_data (q_out)
    );

    assign {b_addr, b_cell, b_flags} = q_out;

    wwg_back #(
        .MAX_WIDTH(MAX_WIDTH),
        .AW       (AW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_addr   (b_addr),
        .i_cell   (b_cell),
        .i_flags  (b_flags),
        .i_restart(restart),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

>>> rtl/wwg_checker.sv
// port-level checks of the wireworld stepper, bound to the top level
// depends on assert_macros.svh and wireworld_generation_step
`include "assert_macros.svh"

module wwg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_next_state,
    input logic       i_last
);

    // a result held back keeps its payload
    `WWG_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next_state) && $stable(i_last))

    // reset empties the output register
    `WWG_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !i_out_valid)

    // the queue is empty after reset, so cells are taken at once
    `WWG_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> i_in_ready)

endmodule

bind wireworld_generation_step wwg_checker u_wwg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_next_state(o_result.next_state),
    .i_last      (o_result.last_of_frame)
);

>>> bench/wireworld_generation_step_tb.sv
// self-checking bench for the streamed wireworld generation stepper
// depends on wwg_pkg, the channel interfaces in wwg_if.sv and wireworld_generation_step
`timescale 1ns / 1ps

module wireworld_generation_step_tb;
    import wwg_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 4096;
    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 5000;

    typedef struct {
        logic [1:0] next_state;
        logic       last;
    } t_next_cell;

    logic i_clk;
    logic i_rst_n;

    wwg_item_if   itm();
    wwg_cfg_if    cfg();
    wwg_result_if res();

    wireworld_generation_step DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (itm),
        .i_cfg    (cfg),
        .o_result (res)
    );

    // predictor state
    logic [1:0] line_above [MAX_W];
    logic [1:0] line_cur [MAX_W];
    logic [1:0] win [3][3];
    int         col_pos;
    int         row_pos;
    int         cells_out;
    int         grid_w;
    int         grid_h;

    t_next_cell next_gen_q[$];
    int         err_count;
    bit         no_idle;
    bit         hold_results;
    int         sink_wait;
    int         idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [1:0] wire_rule(input logic [1:0] s, input int heads);
        case (t_cell'(s))
            ST_HEAD: return ST_TAIL;
            ST_TAIL: return ST_COND;
            ST_COND: return (heads == 1 || heads == 2) ? ST_HEAD : ST_COND;
            default: return ST_EMPTY;
        endcase
    endfunction

    // heads around grid cell (cr, cc) whose state sits in window column ccol
    function automatic int heads_around(input int cr, input int cc, input int ccol);
        int n;
        int r;
        int c;
        int wc;
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                r = cr + dr;
                c = cc + dc;
                wc = ccol + dc;
                if (!(dr == 0 && dc == 0) && r >= 0 && r < grid_h && c >= 0 && c < grid_w
                        && wc >= 0 && wc <= 2 && win[1 + dr][wc] == ST_HEAD)
                    n++;
            end
        end
        return n;
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        cells_out = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = ST_EMPTY;
    endfunction

    function automatic void predict_step(input logic kind, input logic [1:0] cs);
        int ic;
        int ir;
        bit in_data;
        bit emit;
        logic [1:0] ns;
        logic [1:0] v;
        logic [1:0] mid;
        t_next_cell e;
        ic = col_pos;
        ir = row_pos;
        in_data = ir < grid_h;
        emit = 1'b0;
        ns = ST_EMPTY;
        if (kind == KIND_DRAIN && in_data)
            return;
        if (ic >= grid_w)
            ic = 0;
        v = in_data ? cs : ST_EMPTY;
        // row start: last cell of the row two back leaves
        if (ic == 0 && ir >= 2) begin
            ns = wire_rule(win[1][2], heads_around(ir - 2, grid_w - 1, 2));
            emit = 1'b1;
        end
        mid = line_cur[ic];
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = line_above[ic];
        win[1][2] = mid;
        win[2][2] = v;
        line_above[ic] = mid;
        line_cur[ic] = v;
        if (ic >= 1 && ir >= 1) begin
            ns = wire_rule(win[1][1], heads_around(ir - 1, ic - 1, 1));
            emit = 1'b1;
        end
        ic++;
        if (ic >= grid_w) begin
            ic = 0;
            ir++;
        end
        col_pos = ic;
        row_pos = ir;
        if (emit) begin
            e.next_state = ns;
            e.last = (cells_out + 1 >= grid_w * grid_h);
            next_gen_q.push_back(e);
            if (e.last)
                restart_frame();
            else
                cells_out++;
        end
    endfunction

    function automatic int clamp_dim(input int v, input int maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // item monitor feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && itm.valid && itm.ready)
            predict_step(itm.kind, itm.cell_state);
    end

    // result checker
    always @(posedge i_clk) begin
        t_next_cell e;
        if (i_rst_n && res.valid && res.ready) begin
            if (next_gen_q.size() == 0) begin
                $error("unexpected result next_state=%0d last_of_frame=%0d",
                       res.next_state, res.last_of_frame);
                err_count++;
            end else begin
                e = next_gen_q.pop_front();
                if (res.next_state !== e.next_state) begin
                    $error("next_state expected %0d actual %0d", e.next_state, res.next_state);
                    err_count++;
                end
                if (res.last_of_frame !== e.last) begin
                    $error("last_of_frame expected %0d actual %0d", e.last, res.last_of_frame);
                    err_count++;
                end
            end
        end
    end

    // result sink with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            sink_wait <= 0;
        end else if (res.valid && res.ready) begin
            sink_wait <= no_idle ? 0 : $urandom_range(0, 13);
            res.ready <= 1'b0;
        end else if (hold_results || sink_wait > 0) begin
            if (sink_wait > 0)
                sink_wait <= sink_wait - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (itm.valid && itm.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("wireworld_generation_step regression: fail");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [1:0] cs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            itm.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        itm.valid <= 1'b1;
        itm.kind <= kind;
        itm.cell_state <= cs;
        do @(posedge i_clk); while (!itm.ready);
    endtask

    task automatic wait_idle();
        itm.valid <= 1'b0;
        while (next_gen_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_GRID_WIDTH)
            grid_w = clamp_dim(int'(value[WIDTH_REG_W-1:0]), MAX_W);
        else
            grid_h = clamp_dim(int'(value[HEIGHT_REG_W-1:0]), MAX_H);
        restart_frame();
    endtask

    function automatic logic [1:0] rand_cell();
        // lean toward conductors and heads so the neighbor counts vary
        case ($urandom_range(0, 7))
            0: return ST_EMPTY;
            1, 2: return ST_HEAD;
            3: return ST_TAIL;
            default: return ST_COND;
        endcase
    endfunction

    // one frame with random content, plus the drain unless cut_short; noise_pct mixes in stray items
    task automatic run_frame(input int noise_pct, input bit cut_short, inout int sent);
        int n_cells;
        n_cells = grid_w * grid_h;
        if (cut_short)
            n_cells = $urandom_range(1, n_cells);
        for (int i = 0; i < n_cells; i++) begin
            if ($urandom_range(1, 100) <= noise_pct) begin
                send_item(KIND_DRAIN, 2'($urandom_range(0, 3)));
                sent++;
            end
            send_item(KIND_CELL, rand_cell());
            sent++;
        end
        if (!cut_short) begin
            for (int i = 0; i <= grid_w; i++) begin
                // a cell past the end acts as a drain
                if ($urandom_range(1, 100) <= noise_pct)
                    send_item(KIND_CELL, rand_cell());
                else
                    send_item(KIND_DRAIN, 2'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        logic [1:0] pattern [9];
        pattern = '{ST_HEAD, ST_HEAD, ST_HEAD, ST_COND, ST_COND, ST_TAIL,
                    ST_HEAD, ST_COND, ST_EMPTY};
        write_reg(REG_GRID_WIDTH, 13'd3);
        write_reg(REG_GRID_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++) begin
            send_item(KIND_CELL, pattern[i]);
            // drain in the middle of the frame is dropped
            if (i == 4)
                send_item(KIND_DRAIN, ST_COND);
        end
        send_item(KIND_DRAIN, ST_EMPTY);
        send_item(KIND_CELL, ST_HEAD);
        send_item(KIND_DRAIN, ST_TAIL);
        send_item(KIND_DRAIN, ST_EMPTY);
        wait_idle();
    endtask

    task automatic test_extremes();
        int sent;
        sent = 0;
        // zero clamps to one, all-ones clamps to the maximum
        write_reg(REG_GRID_WIDTH, 13'd0);
        write_reg(REG_GRID_HEIGHT, 13'd0);
        run_frame(0, 1'b0, sent);
        // one full row at the widest width, then four cells past the end bring out the first three of row 0
        write_reg(REG_GRID_WIDTH, 13'h1FFF);
        write_reg(REG_GRID_HEIGHT, 13'd1);
        no_idle = 1'b1;
        for (int i = 0; i < MAX_W + 4; i++)
            send_item(KIND_CELL, rand_cell());
        no_idle = 1'b0;
        // tallest grid, one column, only the first rows
        write_reg(REG_GRID_HEIGHT, 13'h1FFF);
        write_reg(REG_GRID_WIDTH, 13'd1);
        for (int i = 0; i < 8; i++)
            send_item(KIND_CELL, rand_cell());
        wait_idle();
    endtask

    task automatic test_backpressure();
        int sent;
        sent = 0;
        write_reg(REG_GRID_WIDTH, 13'd6);
        write_reg(REG_GRID_HEIGHT, 13'd6);
        no_idle = 1'b1;
        fork
            begin
                hold_results = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_results = 1'b0;
            end
        join_none
        run_frame(0, 1'b0, sent);
        run_frame(0, 1'b0, sent);
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int sent;
        int choice;
        sent = 0;
        while (sent < 200) begin
            choice = $urandom_range(0, 9);
            if (choice < 7) begin
                write_reg(REG_GRID_WIDTH, 13'($urandom_range(1, 8)));
                write_reg(REG_GRID_HEIGHT, 13'($urandom_range(1, 8)));
            end else if (choice == 7) begin
                write_reg(REG_GRID_WIDTH, 13'($urandom_range(9, 40)));
                write_reg(REG_GRID_HEIGHT, 13'($urandom_range(1, 6)));
            end else begin
                write_reg(REG_GRID_WIDTH, 13'($urandom_range(1, 5)));
            end
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0)
                    run_frame($urandom_range(10, 40), 1'($urandom_range(0, 1)), sent);
                else
                    run_frame($urandom_range(0, 1) ? 0 : 5, 1'b0, sent);
            end
            no_idle = 1'b0;
        end
        wait_idle();
    endtask

    initial begin
        err_count = 0;
        no_idle = 1'b0;
        hold_results = 1'b0;
        grid_w = 64;
        grid_h = 64;
        for (int i = 0; i < MAX_W; i++) begin
            line_above[i] = ST_EMPTY;
            line_cur[i] = ST_EMPTY;
        end
        restart_frame();
        itm.valid = 1'b0;
        itm.kind = KIND_CELL;
        itm.cell_state = ST_EMPTY;
        cfg.valid = 1'b0;
        cfg.index = REG_GRID_WIDTH;
        cfg.data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_extremes();
        test_backpressure();
        test_random_frames();

        wait_idle();
        if (err_count == 0)
            $display("wireworld_generation_step regression: pass");
        else
            $display("wireworld_generation_step regression: fail");
        $finish;
    end

endmodule
